/* src/debug_packet_receiver_macros.svh */
// Assertion helpers for the debug packet receiver.
`ifndef DEBUG_PACKET_RECEIVER_MACROS_SVH
`define DEBUG_PACKET_RECEIVER_MACROS_SVH

`ifndef SYNTH
`define DPR_ASSERT_CR(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DPR_ASSERT(name, prop, msg) \
  `DPR_ASSERT_CR(name, clk_i, rst_ni, prop, msg)
`else
`define DPR_ASSERT_CR(name, clk, rst_n, prop, msg)
`define DPR_ASSERT(name, prop, msg)
`endif

`endif

/* src/dpr_pkg.sv */
`default_nettype none

package dpr_pkg;

  localparam int unsigned MAX_PAYLOAD = 1024;
  localparam int unsigned CNT_W       = 11;
  localparam int unsigned MAX_RES     = 4;

  localparam logic [6:0] CH_DOLLAR = 7'h24;
  localparam logic [6:0] CH_HASH   = 7'h23;
  localparam logic [6:0] CH_COLON  = 7'h3a;
  localparam logic [6:0] CH_PLUS   = 7'h2b;
  localparam logic [6:0] CH_MINUS  = 7'h2d;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_REPLY   = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  localparam logic [1:0] STAT_GOOD     = 2'd0;
  localparam logic [1:0] STAT_MISMATCH = 2'd1;
  localparam logic [1:0] STAT_OVERFLOW = 2'd2;

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_DATA = 2'd1;
  localparam logic [1:0] PH_HI   = 2'd2;
  localparam logic [1:0] PH_LO   = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] char_value;
    logic [1:0] packet_status;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [2:0]          count;
    result_t [MAX_RES-1:0] res;
  } bundle_t;

  function automatic result_t mk_result(input logic [1:0] kind, input logic [6:0] ch,
                                        input logic [1:0] status);
    result_t r;
    r.kind          = kind;
    r.char_value    = ch;
    r.packet_status = status;
    r.last          = 1'b0;
    return r;
  endfunction

  // Bit 4 flags a valid hex digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_decode(input logic [6:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 7'h61 && c <= 7'h66) begin
      r = {1'b1, 4'(c - 7'h57)};
    end else if (c >= 7'h30 && c <= 7'h39) begin
      r = {1'b1, 4'(c - 7'h30)};
    end else if (c >= 7'h41 && c <= 7'h46) begin
      r = {1'b1, 4'(c - 7'h37)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/dpr_core.sv */
`default_nettype none

module dpr_core import dpr_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] byte_i,
  output bundle_t         bundle_o
);

  logic [1:0]       phase_q, phase_d;
  logic [7:0]       sum_q, sum_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [3:0]       hi_q, hi_d;
  logic [6:0]       held0_q, held0_d;
  logic [6:0]       held1_q, held1_d;
  logic             id_q, id_d;

  logic [6:0]       b;
  logic [CNT_W-1:0] cnt_inc;
  logic [4:0]       hx;
  logic [7:0]       rx_sum;
  bundle_t          bnd;

  assign b       = byte_i[6:0];
  assign cnt_inc = cnt_q + CNT_W'(1);
  assign hx      = hex_decode(b);
  assign rx_sum  = hx[4] ? {hi_q, hx[3:0]} : 8'hff;

  always_comb begin
    phase_d = phase_q;
    sum_d   = sum_q;
    cnt_d   = cnt_q;
    hi_d    = hi_q;
    held0_d = held0_q;
    held1_d = held1_q;
    id_d    = id_q;
    bnd     = '0;

    unique case (phase_q)
      PH_HUNT: begin
        if (b == CH_DOLLAR) begin
          phase_d = PH_DATA;
          sum_d   = 8'd0;
          cnt_d   = '0;
          hi_d    = 4'd0;
          id_d    = 1'b0;
        end
      end
      PH_DATA: begin
        if (b == CH_HASH) begin
          phase_d = PH_HI;
          // A short payload still owes its held bytes.
          if (cnt_q == CNT_W'(1)) begin
            bnd.count  = 3'd1;
            bnd.res[0] = mk_result(KIND_PAYLOAD, held0_q, STAT_GOOD);
          end else if (cnt_q == CNT_W'(2)) begin
            bnd.count  = 3'd2;
            bnd.res[0] = mk_result(KIND_PAYLOAD, held0_q, STAT_GOOD);
            bnd.res[1] = mk_result(KIND_PAYLOAD, held1_q, STAT_GOOD);
          end
        end else begin
          sum_d = sum_q + {1'b0, b};
          cnt_d = cnt_inc;
          if (cnt_inc == CNT_W'(1)) begin
            held0_d = b;
          end else if (cnt_inc == CNT_W'(2)) begin
            held1_d = b;
          end else if (cnt_inc == CNT_W'(3)) begin
            if (b == CH_COLON) begin
              id_d = 1'b1;
            end else begin
              bnd.count  = 3'd3;
              bnd.res[0] = mk_result(KIND_PAYLOAD, held0_q, STAT_GOOD);
              bnd.res[1] = mk_result(KIND_PAYLOAD, held1_q, STAT_GOOD);
              bnd.res[2] = mk_result(KIND_PAYLOAD, b, STAT_GOOD);
            end
          end else begin
            bnd.count  = 3'd1;
            bnd.res[0] = mk_result(KIND_PAYLOAD, b, STAT_GOOD);
          end
          // The count reaches the limit only at four or more bytes, so slot 1 is free.
          if (cnt_inc >= CNT_W'(MAX_PAYLOAD)) begin
            bnd.count  = 3'd2;
            bnd.res[1] = mk_result(KIND_END, 7'd0, STAT_OVERFLOW);
            phase_d    = PH_HUNT;
          end
        end
      end
      PH_HI: begin
        hi_d    = hx[4] ? hx[3:0] : 4'hf;
        phase_d = PH_LO;
      end
      default: begin
        phase_d = PH_HUNT;
        if (rx_sum == sum_q) begin
          bnd.res[0] = mk_result(KIND_REPLY, CH_PLUS, STAT_GOOD);
          if (id_q) begin
            bnd.count  = 3'd4;
            bnd.res[1] = mk_result(KIND_REPLY, held0_q, STAT_GOOD);
            bnd.res[2] = mk_result(KIND_REPLY, held1_q, STAT_GOOD);
            bnd.res[3] = mk_result(KIND_END, 7'd0, STAT_GOOD);
          end else begin
            bnd.count  = 3'd2;
            bnd.res[1] = mk_result(KIND_END, 7'd0, STAT_GOOD);
          end
        end else begin
          bnd.count  = 3'd2;
          bnd.res[0] = mk_result(KIND_REPLY, CH_MINUS, STAT_GOOD);
          bnd.res[1] = mk_result(KIND_END, 7'd0, STAT_MISMATCH);
        end
      end
    endcase

    for (int i = 0; i < MAX_RES; i++) begin
      bnd.res[i].last = (3'(i) == bnd.count - 3'd1);
    end
  end

  assign bundle_o = bnd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      sum_q   <= 8'd0;
      cnt_q   <= '0;
      hi_q    <= 4'd0;
      held0_q <= 7'd0;
      held1_q <= 7'd0;
      id_q    <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      sum_q   <= sum_d;
      cnt_q   <= cnt_d;
      hi_q    <= hi_d;
      held0_q <= held0_d;
      held1_q <= held1_d;
      id_q    <= id_d;
    end
  end

endmodule

`default_nettype wire

/* src/dpr_out_seq.sv */
`default_nettype none

`include "debug_packet_receiver_macros.svh"

module dpr_out_seq import dpr_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  wire bundle_t bundle_i,
  output logic         free_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output result_t      out_o
);

  result_t [MAX_RES-1:0] res_q;
  logic [2:0]            cnt_q;
  logic [1:0]            idx_q;
  logic                  busy_q;

  logic fire;
  logic done;

  assign fire        = busy_q && out_ready_i;
  assign done        = fire && ({1'b0, idx_q} == cnt_q - 3'd1);
  assign free_o      = !busy_q || done;
  assign out_valid_o = busy_q;
  assign out_o       = res_q[idx_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 3'd0;
      idx_q  <= 2'd0;
    end else if (load_i) begin
      // An item with no results leaves the buffer empty.
      busy_q <= (bundle_i.count != 3'd0);
      cnt_q  <= bundle_i.count;
      idx_q  <= 2'd0;
    end else if (done) begin
      busy_q <= 1'b0;
    end else if (fire) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= bundle_i.res;
    end
  end

  `DPR_ASSERT(a_load_when_free, load_i |-> free_o, "item loaded while results still pending")
  `DPR_ASSERT(a_idx_in_range, busy_q |-> ({1'b0, idx_q} < cnt_q), "result index past count")
  `DPR_ASSERT(a_stall_holds, (busy_q && !out_ready_i) |=> (busy_q && $stable(idx_q)), "stalled result moved")
  `DPR_ASSERT(a_last_matches, busy_q |-> (out_o.last == ({1'b0, idx_q} == cnt_q - 3'd1)), "last flag out of place")

endmodule

`default_nettype wire

/* src/debug_packet_receiver.sv */
// Channel   Direction  Handshake               Payload
// input     in         in_valid_i/in_ready_o   rx_byte_i
// result    out        out_valid_o/out_ready_i kind_o, char_value_o, packet_status_o, last_o
//
// A byte is taken while the result buffer is free; its results (zero to four) are registered
// and leave one per cycle while out_ready_i is high; the input waits until the last is taken.
// Bytes with no result (hunting, checksum high digit, held id bytes) flow at one per cycle.
// The next byte is taken in the same cycle as the final result of the previous one.
// Reset (rst_ni low) returns to hunting for the start character with an empty result buffer.
`default_nettype none

module debug_packet_receiver import dpr_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      kind_o,
  output logic [6:0]      char_value_o,
  output logic [1:0]      packet_status_o,
  output logic            last_o
);

  logic    accept;
  logic    free;
  bundle_t bundle;
  result_t res;

  assign in_ready_o = free;
  assign accept     = in_valid_i && free;

  dpr_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (rx_byte_i),
    .bundle_o (bundle)
  );

  dpr_out_seq u_out_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .bundle_i    (bundle),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (res)
  );

  assign kind_o          = res.kind;
  assign char_value_o    = res.char_value;
  assign packet_status_o = res.packet_status;
  assign last_o          = res.last;

endmodule

`default_nettype wire
